[sv/nsdq_pkg.sv]
// Shared types, constants and coefficient tables of the noise-shaped dither quantizer.
package nsdq_pkg;

   localparam int SHAPE_TAPS = 4;
   localparam int TAP_W = $clog2(SHAPE_TAPS);

   localparam logic [9:0]  MUTE_CAP    = 10'd960;
   localparam logic [9:0]  MUTE_DITHER = 10'd16;
   localparam logic [9:0]  MUTE_CLEAR  = 10'd64;
   localparam logic [31:0] SEED_RESET  = 32'd22222;
   localparam logic [31:0] LCG_MUL     = 32'd96314165;
   localparam logic [31:0] LCG_ADD     = 32'd907633515;
   localparam logic signed [15:0] QERR_LIMIT = 16'sd1536;

   localparam logic [1:0] MODE_48K   = 2'd0;
   localparam logic [1:0] MODE_44K   = 2'd1;
   localparam logic [1:0] MODE_PLAIN = 2'd2;

   localparam logic REG_RATE_MODE     = 1'b0;
   localparam logic REG_CHANNEL_COUNT = 1'b1;

   typedef logic signed [15:0] word_type;

   typedef struct packed {
      logic       clear_fb;
      logic       update;
      logic [2:0] chan;
      word_type   err;
      word_type   qe;
   } hist_ctrl_type;

   typedef struct packed {
      logic             active;
      logic [2:0]       chan;
      logic [TAP_W-1:0] tap;
      logic             fb_sel;
   } hist_rd_type;

   function automatic word_type coef_of(input logic [1:0] mode, input logic [2:0] k);
      word_type c;
      c = 16'sd0;
      case (mode)
         MODE_48K: begin
            case (k)
               3'd0: c = 16'sd9164;
               3'd1: c = -16'sd3006;
               3'd2: c = -16'sd512;
               3'd3: c = -16'sd2471;
               3'd4: c = 16'sd3699;
               3'd5: c = 16'sd48;
               3'd6: c = -16'sd2397;
               default: c = -16'sd1053;
            endcase
         end
         MODE_44K: begin
            case (k)
               3'd0: c = 16'sd9036;
               3'd1: c = -16'sd1928;
               3'd2: c = -16'sd1038;
               3'd3: c = -16'sd2545;
               3'd4: c = 16'sd4336;
               3'd5: c = 16'sd277;
               3'd6: c = -16'sd2480;
               default: c = -16'sd1121;
            endcase
         end
         default: begin
            c = (k == 3'd0) ? 16'sd4096 : 16'sd0;
         end
      endcase
      return c;
   endfunction

   function automatic word_type gain_of(input logic [1:0] mode);
      word_type g;
      case (mode)
         MODE_48K: g = 16'sd32753;
         MODE_44K: g = 16'sd32753;
         default:  g = 16'sd32765;
      endcase
      return g;
   endfunction

endpackage

[sv/nsdq_mul.sv]
// Shared signed 32 by 32 multiplier with a registered product.
module nsdq_mul (
   input  logic               clock,
   input  logic signed [31:0] mul_a,
   input  logic signed [31:0] mul_b,
   output logic signed [63:0] prod
);

   logic signed [63:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign prod = prod_ff;

endmodule

[sv/nsdq_hist.sv]
// Per-channel shaping and quantization error histories with one tap read port.
module nsdq_hist
   import nsdq_pkg::*;
#(
   parameter int MAX_CHANNELS = 2
) (
   input  logic          clock,
   input  logic          reset,
   input  hist_ctrl_type ctrl,
   input  hist_rd_type   rd,
   output word_type      rd_data
);

   localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam logic [3:0] MaxCnt = 4'(MAX_CHANNELS);

   word_type fb_ff [MAX_CHANNELS][SHAPE_TAPS];
   word_type qe_ff [MAX_CHANNELS][SHAPE_TAPS];

   logic [CW-1:0] rd_sel;
   logic [CW-1:0] wr_sel;
   logic          rd_ok;
   logic          wr_ok;

   assign rd_sel = rd.chan[CW-1:0];
   assign wr_sel = ctrl.chan[CW-1:0];
   assign rd_ok  = rd.active && ({1'b0, rd.chan} < MaxCnt);
   assign wr_ok  = ctrl.update && ({1'b0, ctrl.chan} < MaxCnt);

   always_comb begin
      rd_data = 16'sd0;
      if (rd_ok) begin
         rd_data = rd.fb_sel ? fb_ff[rd_sel][rd.tap] : qe_ff[rd_sel][rd.tap];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < MAX_CHANNELS; c++) begin
            for (int j = 0; j < SHAPE_TAPS; j++) begin
               fb_ff[c][j] <= 16'sd0;
               qe_ff[c][j] <= 16'sd0;
            end
         end
      end else begin
         if (ctrl.clear_fb) begin
            for (int c = 0; c < MAX_CHANNELS; c++) begin
               for (int j = 0; j < SHAPE_TAPS; j++) begin
                  fb_ff[c][j] <= 16'sd0;
               end
            end
         end
         if (wr_ok) begin
            for (int j = SHAPE_TAPS - 1; j > 0; j--) begin
               fb_ff[wr_sel][j] <= fb_ff[wr_sel][j-1];
               qe_ff[wr_sel][j] <= qe_ff[wr_sel][j-1];
            end
            fb_ff[wr_sel][0] <= ctrl.err;
            qe_ff[wr_sel][0] <= ctrl.qe;
         end
      end
   end

endmodule

[sv/noise_shaped_dither_quantizer_core.sv]
// Top level of the noise-shaped triangular dither quantizer to 16-bit PCM.
//
// A sample enters on the req_ channel (valid/ready) as a 24-bit signed fraction
// with its channel index and a call start flag; one 16-bit PCM sample leaves on
// the rsp_ channel for every input transfer. The user must write rate mode and
// channel count through csr_ only while the block is idle; the block does not enforce it.
// One sequencer drives a single shared 32x32 multiplier through the gain, the
// eight shaping taps and the two random draws, then rounds in four more steps.
// The block takes no new item until the sequencer has finished the last one,
// stepping it through the multiplier schedule and the rounding states.
// req_ready is high only while the sequencer is idle.
// The result sits in an output register, so a new item is accepted while it
// waits; if the receiver still stalls when the next result is done, the
// sequencer holds that result and its state update until the register frees.
// Synchronous reset empties the output, clears the histories, loads the seed
// and the silence counter, and selects the 48 kHz filter with two channels.
module noise_shaped_dither_quantizer_core
   import nsdq_pkg::*;
#(
   parameter int MAX_CHANNELS = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [23:0] req_sample_in,
   input  logic [2:0]         req_channel_index,
   input  logic               req_call_start,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_pcm_out,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [3:0]         csr_wdata
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_SUM  = 3'd2;
   localparam logic [2:0] S_ADD  = 3'd3;
   localparam logic [2:0] S_RND  = 3'd4;
   localparam logic [2:0] S_UPD  = 3'd5;

   localparam logic [3:0] STEP_GAIN    = 4'd0;
   localparam logic [3:0] STEP_V       = 4'd1;
   localparam logic [3:0] STEP_QE_LAST = 4'(SHAPE_TAPS);
   localparam logic [3:0] STEP_FB_LAST = 4'(2 * SHAPE_TAPS);
   localparam logic [3:0] STEP_DRAW1  = STEP_FB_LAST + 4'd1;
   localparam logic [3:0] STEP_ERR    = STEP_FB_LAST + 4'd2;
   localparam logic [3:0] STEP_DRAW2  = STEP_FB_LAST + 4'd3;
   localparam logic [3:0] STEP_LAST   = STEP_FB_LAST + 4'd4;
   localparam logic [3:0] MaxCnt      = 4'(MAX_CHANNELS);

   logic [2:0]         state_ff;
   logic [3:0]         step_ff;
   logic signed [23:0] x_ff;
   logic [2:0]         ch_ff;
   logic [1:0]         rate_mode_ff;
   logic [3:0]         channel_count_ff;
   logic signed [40:0] v_ff;
   logic signed [33:0] acc_ff;
   word_type           err_ff;
   logic [31:0]        u1_ff;
   logic [31:0]        u2_ff;
   logic [31:0]        seed_ff;
   logic signed [23:0] r23_ff;
   logic signed [41:0] t_ff;
   logic signed [15:0] q_ff;
   logic [9:0]         silence_ff;
   logic               faz_ff;
   logic               rsp_valid_ff;
   logic signed [15:0] rsp_pcm_ff;

   logic [1:0]         mode;
   logic [3:0]         eff;
   logic               active;
   logic               muted;
   logic               frame_end;
   logic               in_xfer;
   logic               out_free;
   logic signed [31:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [63:0] prod;
   hist_rd_type        hrd;
   hist_ctrl_type      hctl;
   word_type           tap_data;
   logic signed [34:0] acc_rnd;
   logic signed [22:0] err_full;
   word_type           err_in;
   logic [31:0]        draw;
   logic signed [32:0] draw_diff;
   logic signed [18:0] q_floor;
   logic [22:0]        q_rem;
   logic               q_up;
   logic signed [19:0] q_wide;
   logic signed [15:0] q_in;
   logic signed [42:0] e_rnd;
   logic signed [29:0] qe_full;
   word_type           qe_in;

   assign mode = (rate_mode_ff > MODE_PLAIN) ? MODE_PLAIN : rate_mode_ff;
   assign eff = (channel_count_ff == 4'd0) ? 4'd1 :
                ((channel_count_ff > MaxCnt) ? MaxCnt : channel_count_ff);
   assign active    = ({1'b0, ch_ff} < eff);
   assign frame_end = ({1'b0, ch_ff} == (eff - 4'd1));
   assign muted     = (silence_ff > MUTE_DITHER);
   assign in_xfer   = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      hrd.active = active;
      hrd.chan   = ch_ff;
      hrd.fb_sel = (step_ff > STEP_QE_LAST);
      hrd.tap    = (step_ff > STEP_QE_LAST) ? TAP_W'(step_ff - STEP_QE_LAST - 4'd1)
                                            : TAP_W'(step_ff - 4'd1);
   end

   always_comb begin
      mul_a = 32'sd0;
      mul_b = 32'sd0;
      if (step_ff == STEP_GAIN) begin
         mul_a = 32'(x_ff);
         mul_b = 32'(gain_of(mode));
      end else if (step_ff <= STEP_FB_LAST) begin
         mul_a = 32'(coef_of(mode, {hrd.fb_sel, hrd.tap}));
         mul_b = 32'(tap_data);
      end else if (step_ff == STEP_DRAW1) begin
         mul_a = $signed(seed_ff);
         mul_b = $signed(LCG_MUL);
      end else begin
         mul_a = $signed(u1_ff);
         mul_b = $signed(LCG_MUL);
      end
   end

   nsdq_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   always_comb begin
      acc_rnd  = 35'(acc_ff) + 35'sd2048;
      err_full = acc_rnd[34:12];
      if (!active) begin
         err_in = 16'sd0;
      end else if (err_full > 23'sd32767) begin
         err_in = 16'sd32767;
      end else if (err_full < -23'sd32768) begin
         err_in = -16'sd32768;
      end else begin
         err_in = err_full[15:0];
      end
   end

   assign draw      = prod[31:0] + LCG_ADD;
   assign draw_diff = $signed({1'b0, u1_ff}) - $signed({1'b0, u2_ff});

   always_comb begin
      q_floor = t_ff[41:23];
      q_rem   = t_ff[22:0];
      q_up    = (q_rem > 23'h400000) || ((q_rem == 23'h400000) && q_floor[0]);
      q_wide  = 20'(q_floor) + 20'(q_up);
      if (q_wide > 20'sd32767) begin
         q_in = 16'sd32767;
      end else if (q_wide < -20'sd32768) begin
         q_in = -16'sd32768;
      end else begin
         q_in = q_wide[15:0];
      end
   end

   always_comb begin
      e_rnd   = (43'(q_ff) <<< 23) - 43'(v_ff) + 43'sd4096;
      qe_full = e_rnd[42:13];
      if (muted) begin
         qe_in = 16'sd0;
      end else if (qe_full > 30'(QERR_LIMIT)) begin
         qe_in = QERR_LIMIT;
      end else if (qe_full < -30'(QERR_LIMIT)) begin
         qe_in = -QERR_LIMIT;
      end else begin
         qe_in = qe_full[15:0];
      end
   end

   always_comb begin
      hctl.clear_fb = in_xfer && req_call_start && (silence_ff > MUTE_CLEAR);
      hctl.update   = (state_ff == S_UPD) && out_free && active;
      hctl.chan     = ch_ff;
      hctl.err      = err_ff;
      hctl.qe       = qe_in;
   end

   nsdq_hist #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_hist (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (hctl),
      .rd      (hrd),
      .rd_data (tap_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_mode_ff     <= MODE_48K;
         channel_count_ff <= 4'd2;
      end else if (csr_we) begin
         case (csr_index)
            REG_RATE_MODE:     rate_mode_ff <= csr_wdata[1:0];
            REG_CHANNEL_COUNT: channel_count_ff <= csr_wdata;
            default:           rate_mode_ff <= rate_mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= STEP_GAIN;
         seed_ff      <= SEED_RESET;
         silence_ff   <= MUTE_CAP;
         faz_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != S_UPD)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (in_xfer) begin
                  x_ff    <= req_sample_in;
                  ch_ff   <= req_channel_index;
                  step_ff <= STEP_GAIN;
                  state_ff <= S_MUL;
                  if (req_sample_in != 24'sd0) begin
                     faz_ff <= 1'b0;
                  end
               end
            end
            S_MUL: begin
               step_ff <= step_ff + 4'd1;
               if (step_ff == STEP_V) begin
                  v_ff   <= prod[40:0];
                  acc_ff <= 34'sd0;
               end else if (step_ff > STEP_V && step_ff <= STEP_QE_LAST + 4'd1) begin
                  acc_ff <= acc_ff + prod[33:0];
               end else if (step_ff > STEP_QE_LAST + 4'd1 && step_ff <= STEP_DRAW1) begin
                  acc_ff <= acc_ff - prod[33:0];
               end
               if (step_ff == STEP_ERR) begin
                  u1_ff  <= draw;
                  err_ff <= err_in;
               end
               if (step_ff == STEP_DRAW2) begin
                  v_ff <= v_ff - (41'(err_ff) <<< 13);
               end
               if (step_ff == STEP_LAST) begin
                  u2_ff    <= draw;
                  seed_ff  <= draw;
                  state_ff <= S_SUM;
               end
            end
            S_SUM: begin
               r23_ff   <= muted ? 24'sd0 : draw_diff[32:9];
               state_ff <= S_ADD;
            end
            S_ADD: begin
               t_ff     <= 42'(v_ff) + 42'(r23_ff);
               state_ff <= S_RND;
            end
            S_RND: begin
               q_ff     <= q_in;
               state_ff <= S_UPD;
            end
            S_UPD: begin
               if (out_free) begin
                  rsp_pcm_ff   <= q_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
                  if (frame_end) begin
                     if (!faz_ff) begin
                        silence_ff <= 10'd0;
                     end else if (silence_ff < MUTE_CAP) begin
                        silence_ff <= silence_ff + 10'd1;
                     end
                     faz_ff <= 1'b1;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pcm_out = rsp_pcm_ff;

endmodule

[sv/nsdq_checker.sv]
// Port-level checks of the quantizer core and their attachment to it.
module nsdq_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_pcm_out
);

   // A result that is not taken stays in place.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pcm_out))
      else $error("stalled result changed or dropped");

   // The block works on one item at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while an item is in progress");

   // The sequencer stays busy for at least the full schedule after a transfer.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready [*17])
      else $error("input ready before the item schedule finished");

   // Reset empties the output register.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown after reset");

endmodule

bind noise_shaped_dither_quantizer_core nsdq_checker u_nsdq_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_pcm_out (rsp_pcm_out)
);

[tb/sv/tb_noise_shaped_dither_quantizer_core.sv]
// Self-checking testbench for the noise-shaped dither quantizer core, with its own model.
module tb_noise_shaped_dither_quantizer_core;
   import nsdq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_CH = 2;
   localparam int TAPS = 4;
   localparam int HIST_DEPTH = MAX_CH * TAPS;
   localparam int SILENCE_CAP = 960;
   localparam int DITHER_OFF_FRAMES = 16;
   localparam int CLEAR_FRAMES = 64;
   localparam logic [31:0] SEED_INIT = 32'd22222;
   localparam logic [31:0] DRAW_MUL = 32'd96314165;
   localparam logic [31:0] DRAW_ADD = 32'd907633515;
   localparam longint QERR_MAX = 1536;
   localparam int SETTLE_CYCLES = 24;
   localparam int LONG_HOLD = 300;
   localparam int STALL_LIMIT = 4000;

   typedef struct {
      logic signed [23:0] smp;
      logic [2:0]         ch;
      logic               first;
   } sample_item_t;

   logic               clock;
   logic               reset;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [23:0] req_sample_in = '0;
   logic [2:0]         req_channel_index = '0;
   logic               req_call_start = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_pcm_out;
   logic               csr_we;
   logic               csr_index;
   logic [3:0]         csr_wdata;

   sample_item_t       sample_backlog[$];
   logic signed [15:0] expected_pcm[$];

   logic        req_taken = 1'b0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          hold_token = 0;
   int          hold_seen = 0;
   int          hold_left = 0;
   int          frame_chans = 2;
   int          error_count = 0;
   int          samples_sent = 0;
   int          results_checked = 0;
   int          idle_cycles = 0;
   int          muted_items = 0;
   int          clear_events = 0;
   int          spare_chan_items = 0;

   logic [1:0]  rate_reg;
   logic [3:0]  count_reg;
   int          fb_hist [0:HIST_DEPTH-1];
   int          qerr_hist [0:HIST_DEPTH-1];
   int          silence_run;
   logic [31:0] draw_seed;
   bit          frame_quiet;

   noise_shaped_dither_quantizer_core #(
      .MAX_CHANNELS(MAX_CH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample_in(req_sample_in),
      .req_channel_index(req_channel_index),
      .req_call_start(req_call_start),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_pcm_out(rsp_pcm_out),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint clamp_range(input longint val, input longint lo, input longint hi);
      return (val < lo) ? lo : ((val > hi) ? hi : val);
   endfunction

   function automatic longint filter_coef(input int mode, input int k);
      longint c;
      c = 0;
      case (mode)
         0: begin
            case (k)
               0: c = 9164;
               1: c = -3006;
               2: c = -512;
               3: c = -2471;
               4: c = 3699;
               5: c = 48;
               6: c = -2397;
               default: c = -1053;
            endcase
         end
         1: begin
            case (k)
               0: c = 9036;
               1: c = -1928;
               2: c = -1038;
               3: c = -2545;
               4: c = 4336;
               5: c = 277;
               6: c = -2480;
               default: c = -1121;
            endcase
         end
         default: begin
            c = (k == 0) ? 4096 : 0;
         end
      endcase
      return c;
   endfunction

   function automatic void reset_model();
      rate_reg = MODE_48K;
      count_reg = 4'd2;
      foreach (fb_hist[i]) fb_hist[i] = 0;
      foreach (qerr_hist[i]) qerr_hist[i] = 0;
      silence_run = SILENCE_CAP;
      draw_seed = SEED_INIT;
      frame_quiet = 1'b1;
   endfunction

   function automatic logic signed [15:0] requantize(input logic signed [23:0] smp,
                                                     input logic [2:0] ch, input logic first);
      longint x, v, acc, err, t, q, rem, r23, e23, qe;
      int mode, eff, base, j;
      bit active, muted;
      logic [31:0] draw1, draw2;
      x = smp;
      mode = (rate_reg > 2) ? 2 : int'(rate_reg);
      eff = int'(count_reg);
      if (eff < 1) eff = 1;
      if (eff > MAX_CH) eff = MAX_CH;
      active = (ch < eff);
      if (first && silence_run > CLEAR_FRAMES) begin
         foreach (fb_hist[i]) fb_hist[i] = 0;
         clear_events++;
      end
      muted = (silence_run > DITHER_OFF_FRAMES);
      if (muted) muted_items++;
      if (!active) spare_chan_items++;
      if (x != 0) frame_quiet = 1'b0;
      v = x * ((mode == 2) ? 32765 : 32753);
      err = 0;
      if (active) begin
         base = ch * TAPS;
         acc = 0;
         for (j = 0; j < TAPS; j++) begin
            acc += filter_coef(mode, j) * qerr_hist[base + j];
            acc -= filter_coef(mode, j + 4) * fb_hist[base + j];
         end
         err = clamp_range((acc + 2048) >>> 12, -32768, 32767);
         for (j = TAPS - 1; j > 0; j--) begin
            fb_hist[base + j] = fb_hist[base + j - 1];
            qerr_hist[base + j] = qerr_hist[base + j - 1];
         end
         fb_hist[base] = int'(err);
      end
      v = v - err * 8192;
      draw_seed = draw_seed * DRAW_MUL + DRAW_ADD;
      draw1 = draw_seed;
      draw_seed = draw_seed * DRAW_MUL + DRAW_ADD;
      draw2 = draw_seed;
      r23 = (longint'({32'd0, draw1}) - longint'({32'd0, draw2})) >>> 9;
      if (muted) r23 = 0;
      t = v + r23;
      q = t >>> 23;
      rem = t - q * 8388608;
      if (rem > 4194304 || (rem == 4194304 && q[0])) q++;
      q = clamp_range(q, -32768, 32767);
      if (active) begin
         e23 = q * 8388608 - v;
         qe = clamp_range((e23 + 4096) >>> 13, -QERR_MAX, QERR_MAX);
         qerr_hist[ch * TAPS] = muted ? 0 : int'(qe);
      end
      if (ch == eff - 1) begin
         if (silence_run < SILENCE_CAP) silence_run++;
         if (!frame_quiet) silence_run = 0;
         frame_quiet = 1'b1;
      end
      return q[15:0];
   endfunction

   // Model update, result checking and the stall watchdog all run on the rising edge.
   always @(posedge clock) begin : monitor
      logic signed [15:0] want;
      req_taken <= req_valid && req_ready && !reset;
      if (reset) begin
         reset_model();
         idle_cycles = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == REG_RATE_MODE) rate_reg = csr_wdata[1:0];
            else count_reg = csr_wdata;
         end
         if (req_valid && req_ready) begin
            expected_pcm.push_back(requantize(req_sample_in, req_channel_index,
                                              req_call_start));
            samples_sent++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_pcm.size() == 0) begin
               error_count++;
               $display("%0t ns: result %0d arrived with no sample outstanding",
                        $time, rsp_pcm_out);
            end else begin
               want = expected_pcm.pop_front();
               results_checked++;
               if (rsp_pcm_out !== want) begin
                  error_count++;
                  $display("%0t ns: pcm_out mismatch, expected %0d, actual %0d",
                           $time, want, rsp_pcm_out);
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL noise_shaped_dither_quantizer_core");
            $finish;
         end
      end
   end

   always @(negedge clock) begin : driver
      sample_item_t nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (sample_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            nxt = sample_backlog.pop_front();
            req_valid <= 1'b1;
            req_sample_in <= nxt.smp;
            req_channel_index <= nxt.ch;
            req_call_start <= nxt.first;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_seen != hold_token) begin
         hold_seen = hold_token;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   task automatic add_sample(input logic signed [23:0] smp, input logic [2:0] ch,
                             input logic first);
      sample_item_t it;
      it.smp = smp;
      it.ch = ch;
      it.first = first;
      sample_backlog.push_back(it);
   endtask

   function automatic logic signed [23:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
         1, 2, 3: return 24'($urandom_range(0, 4000) - 2000);
         4, 5: return 24'($signed($urandom()) >>> $urandom_range(8, 20));
         default: return 24'($urandom());
      endcase
   endfunction

   // Mostly well-formed blocks of frames, some silent runs around the mute and clear
   // thresholds, and a little noise with arbitrary channels and start flags.
   task automatic add_traffic(input int n);
      int added, kind, frames, f, c;
      bit silent, start_block;
      added = 0;
      while (added < n) begin
         kind = $urandom_range(0, 19);
         if (kind >= 16) begin
            repeat ($urandom_range(1, 4)) begin
               add_sample($urandom_range(0, 3) == 0 ? 24'sd0 : pick_sample(),
                          3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
               added++;
            end
         end else begin
            silent = (kind >= 12);
            if (kind < 12) frames = $urandom_range(1, 6);
            else if (kind < 15) frames = $urandom_range(14, 22);
            else frames = $urandom_range(62, 70);
            start_block = ($urandom_range(0, 2) != 0);
            for (f = 0; f < frames && added < n; f++) begin
               for (c = 0; c < frame_chans; c++) begin
                  add_sample(silent ? 24'sd0 : pick_sample(), 3'(c),
                             start_block && f == 0 && c == 0);
                  added++;
               end
            end
         end
      end
   endtask

   task automatic write_reg(input logic idx, input logic [3:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (sample_backlog.size() != 0 || req_valid || expected_pcm.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [1:0] rate, input logic [3:0] count,
                            input int sidle, input int ridle, input int n,
                            input bit long_hold);
      wait_drained();
      write_reg(REG_RATE_MODE, {2'b00, rate});
      write_reg(REG_CHANNEL_COUNT, count);
      frame_chans = (count < 1) ? 1 : ((count > MAX_CH) ? MAX_CH : int'(count));
      send_idle_pct = sidle;
      recv_stall_pct = ridle;
      @(posedge clock);
      add_traffic(n);
      if (long_hold) hold_token++;
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = REG_RATE_MODE;
      csr_wdata = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_reg(REG_RATE_MODE, {2'b00, MODE_48K});
      write_reg(REG_CHANNEL_COUNT, 4'd2);
      @(posedge clock);
      add_sample(24'sd0, 3'd0, 1'b1);
      add_sample(24'sd0, 3'd1, 1'b0);
      add_sample(24'sh7FFFFF, 3'd0, 1'b1);
      add_sample(24'sh800000, 3'd1, 1'b0);
      add_sample(24'sh800000, 3'd0, 1'b0);
      add_sample(24'sh7FFFFF, 3'd1, 1'b0);
      add_sample(24'sd1, 3'd0, 1'b0);
      add_sample(-24'sd1, 3'd1, 1'b0);
      add_sample(24'sd256, 3'd0, 1'b1);
      add_sample(-24'sd256, 3'd1, 1'b0);
      add_sample(24'sh400000, 3'd2, 1'b0);
      add_sample(-24'sh400000, 3'd7, 1'b0);
      add_sample(24'sh123456, 3'd5, 1'b1);
      add_sample(24'sh555555, 3'd3, 1'b0);
      add_sample(24'shAAAAAA, 3'd4, 1'b0);
      add_sample(24'sh2AAAAA, 3'd6, 1'b0);
      add_sample(24'sd0, 3'd0, 1'b0);
      add_sample(24'sd0, 3'd1, 1'b0);
      add_sample(24'sh000800, 3'd0, 1'b0);
      add_sample(-24'sh000800, 3'd1, 1'b0);
      add_traffic(130);

      run_phase(MODE_44K, 4'd1, 52, 0, 140, 1'b0);
      run_phase(MODE_PLAIN, 4'd8, 0, 52, 140, 1'b1);
      run_phase(2'd3, 4'd0, 28, 28, 140, 1'b0);
      run_phase(MODE_48K, 4'd15, 52, 0, 130, 1'b0);
      run_phase(MODE_44K, 4'd2, 0, 0, 130, 1'b0);
      wait_drained();

      $display("Sent %0d samples and checked %0d results over six rate and channel settings.",
               samples_sent, results_checked);
      $display("Muted samples: %0d, history clears: %0d, samples on unused channels: %0d.",
               muted_items, clear_events, spare_chan_items);
      if (error_count == 0)
         $display("PASS noise_shaped_dither_quantizer_core");
      else
         $display("FAIL noise_shaped_dither_quantizer_core");
      $finish;
   end

endmodule
